FILE: rtl/lavm_pkg.sv
// Shared constants, types and helpers for the look-at view matrix generator.
`timescale 1ns / 1ps

package lavm_pkg;

  // Default number of fraction bits of every fixed-point value.
  localparam int unsigned FRAC_BITS = 16;
  // Width of one coordinate on the ports.
  localparam int unsigned DATA_W = 32;
  // Width of the working word used by the truncating shift helper.
  localparam int unsigned SHR_W = 72;

  // Matrix row codes, also the order in which rows leave the block.
  typedef enum logic [1:0] {
    ROW_U = 2'd0,
    ROW_V = 2'd1,
    ROW_W = 2'd2
  } row_e;

  // Arithmetic right shift that rounds toward zero instead of toward minus infinity.
  function automatic logic signed [SHR_W-1:0] shr_tz(input logic signed [SHR_W-1:0] a,
                                                     input int unsigned sh);
    logic [SHR_W-1:0] m;
    logic [SHR_W-1:0] r;
    m = a[SHR_W-1] ? SHR_W'(-a) : SHR_W'(a);
    r = m >> sh;
    return a[SHR_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

FILE: rtl/lavm_norm.sv
// Pipelined vector normalizer: prescale, sum of squares, square root and division stages.
`timescale 1ns / 1ps

module lavm_norm #(
  parameter int unsigned FRAC_BITS = lavm_pkg::FRAC_BITS,
  parameter int unsigned IN_W      = lavm_pkg::DATA_W,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [2:0][IN_W-1:0]           vec_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic [2:0][FRAC_BITS+1:0]      vec_o,
  output logic                           zero_o,
  output logic [SIDE_W-1:0]              side_o
);

  localparam int unsigned MAG_W     = lavm_pkg::DATA_W - 1;
  localparam int unsigned SUM_W     = 2 * MAG_W + 2;
  localparam int unsigned ROOT_W    = SUM_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned OUT_W     = FRAC_BITS + 2;
  localparam int unsigned SH_W      = $clog2(IN_W - MAG_W + 1);

  typedef struct packed {
    logic [2:0][MAG_W-1:0] tmag;
    logic [2:0]            sgn;
    logic                  zero;
    logic [SIDE_W-1:0]     side;
  } sq_carry_t;

  typedef struct packed {
    logic [2:0]        tlsb;
    logic [2:0]        sgn;
    logic              zero;
    logic [ROOT_W-1:0] len;
    logic [SIDE_W-1:0] side;
  } dv_carry_t;

  // Stage A: magnitudes and signs.
  logic                  a_v_q;
  logic [IN_W-1:0]       a_mag_q [3];
  logic [2:0]            a_sgn_q;
  logic [SIDE_W-1:0]     a_side_q;
  // Stage B: prescaled magnitudes.
  logic                  b_v_q;
  logic [MAG_W-1:0]      b_t_q [3];
  logic [2:0]            b_sgn_q;
  logic [SIDE_W-1:0]     b_side_q;
  logic [IN_W-1:0]       orv;
  logic [SH_W-1:0]       sh;
  // Stage C: squares.
  logic                  c_v_q;
  logic [2*MAG_W-1:0]    c_sq_q [3];
  logic [2:0][MAG_W-1:0] c_t_q;
  logic [2:0]            c_sgn_q;
  logic                  c_zero_q;
  logic [SIDE_W-1:0]     c_side_q;
  // Square root stages; index 0 holds the sum of squares.
  logic                  sq_v_q    [0:ROOT_W];
  logic [SUM_W-1:0]      sq_rad_q  [0:ROOT_W];
  logic [REM_W-1:0]      sq_rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0]     sq_root_q [0:ROOT_W];
  sq_carry_t             sq_c_q    [0:ROOT_W];
  // Division stages, three lanes each.
  logic                  dv_v_q [0:DIV_STEPS];
  logic [ROOT_W-1:0]     dv_r_q [0:DIV_STEPS][3];
  logic [DIV_STEPS-1:0]  dv_q_q [0:DIV_STEPS][3];
  dv_carry_t             dv_c_q [0:DIV_STEPS];
  // Output stage.
  logic                  o_v_q;
  logic [2:0][OUT_W-1:0] o_vec_q;
  logic                  o_zero_q;
  logic [SIDE_W-1:0]     o_side_q;

  always_comb begin
    orv = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    sh  = '0;
    for (int j = MAG_W; j < IN_W; j++) begin
      if (orv[j]) sh = SH_W'(j - (MAG_W - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      sq_v_q[0] <= 1'b0;
      dv_v_q[0] <= 1'b0;
      o_v_q     <= 1'b0;
    end else if (en_i) begin
      a_v_q     <= valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      sq_v_q[0] <= c_v_q;
      dv_v_q[0] <= sq_v_q[ROOT_W];
      o_v_q     <= dv_v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        a_mag_q[k] <= vec_i[k][IN_W-1] ? IN_W'(-$signed(vec_i[k])) : vec_i[k];
        a_sgn_q[k] <= vec_i[k][IN_W-1];
        b_t_q[k]   <= MAG_W'(a_mag_q[k] >> sh);
        c_sq_q[k]  <= (2*MAG_W)'(b_t_q[k]) * (2*MAG_W)'(b_t_q[k]);
        c_t_q[k]   <= b_t_q[k];
      end
      a_side_q <= side_i;
      b_sgn_q  <= a_sgn_q;
      b_side_q <= a_side_q;
      c_sgn_q  <= b_sgn_q;
      c_zero_q <= ~|{b_t_q[0], b_t_q[1], b_t_q[2]};
      c_side_q <= b_side_q;

      sq_rad_q[0]  <= SUM_W'(c_sq_q[0]) + SUM_W'(c_sq_q[1]) + SUM_W'(c_sq_q[2]);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_c_q[0]    <= '{tmag: c_t_q, sgn: c_sgn_q, zero: c_zero_q, side: c_side_q};

      for (int k = 0; k < 3; k++) begin
        dv_r_q[0][k]     <= ROOT_W'(sq_c_q[ROOT_W].tmag[k] >> 1);
        dv_q_q[0][k]     <= '0;
        dv_c_q[0].tlsb[k] <= sq_c_q[ROOT_W].tmag[k][0];
      end
      dv_c_q[0].sgn  <= sq_c_q[ROOT_W].sgn;
      dv_c_q[0].zero <= sq_c_q[ROOT_W].zero;
      dv_c_q[0].len  <= sq_root_q[ROOT_W];
      dv_c_q[0].side <= sq_c_q[ROOT_W].side;

      for (int k = 0; k < 3; k++) begin
        o_vec_q[k] <= dv_c_q[DIV_STEPS].sgn[k] ? -OUT_W'(dv_q_q[DIV_STEPS][k])
                                               : OUT_W'(dv_q_q[DIV_STEPS][k]);
      end
      o_zero_q <= dv_c_q[DIV_STEPS].zero;
      o_side_q <= dv_c_q[DIV_STEPS].side;
    end
  end

  // One root bit per stage, two radicand bits consumed per stage.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {sq_rem_q[i], sq_rad_q[i][SUM_W-1 -: 2]};
      trial = (REM_W+2)'({sq_root_q[i], 2'b01});
      ge    = cur >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[i+1] <= sq_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rad_q[i+1]  <= sq_rad_q[i] << 2;
        sq_rem_q[i+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        sq_root_q[i+1] <= {sq_root_q[i][ROOT_W-2:0], ge};
        sq_c_q[i+1]    <= sq_c_q[i];
      end
    end
  end

  // Restoring division, one quotient bit per stage; the dividend is the
  // magnitude shifted up by the fraction bits, so only its lowest bit enters late.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [ROOT_W:0]   sh_r [3];
    logic [2:0]        ge;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        sh_r[k] = {dv_r_q[j][k], (j == 0) ? dv_c_q[j].tlsb[k] : 1'b0};
        ge[k]   = sh_r[k] >= {1'b0, dv_c_q[j].len};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          dv_r_q[j+1][k] <= ge[k] ? ROOT_W'(sh_r[k] - {1'b0, dv_c_q[j].len})
                                  : ROOT_W'(sh_r[k]);
          dv_q_q[j+1][k] <= {dv_q_q[j][k][DIV_STEPS-2:0], ge[k]};
        end
        dv_c_q[j+1] <= dv_c_q[j];
      end
    end
  end

  assign valid_o = o_v_q;
  assign vec_o   = o_vec_q;
  assign zero_o  = o_zero_q;
  assign side_o  = o_side_q;

endmodule

FILE: rtl/look_at_view_matrix.sv
// Top level of the look-at view matrix generator: basis pipeline and row output stage.
`timescale 1ns / 1ps
//
// Channel   Dir  Fields (tdata / tuser / tlast)
// s_axis    in   look_x,y,z, up_x,y,z, eye_x,y,z in tdata, 32 bits each
// m_axis    out  elem_a,b,c,t in tdata; row_index, degenerate in tuser; last_row as tlast
//
// One request yields three rows on m_axis, so a new request is taken only when the holding
// stage is empty or hands over its last row; the single row output port sets the request rate.
// The path from acceptance to the first row is dominated by the two normalizers,
// each with a 32-stage root and a FRAC_BITS+1 stage divider.
// Reset clears every valid bit and the row counter; no clearing pass is needed.
// A stall on m_axis freezes the whole pipeline in place, so nothing is lost or repeated.

module look_at_view_matrix #(
  parameter int unsigned FRAC_BITS = lavm_pkg::FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // look_x, look_y, look_z, up_x, up_y, up_z, eye_x, eye_y, eye_z from bit 0 up.
  input  logic [287:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // elem_a, elem_b, elem_c, elem_t from bit 0 up.
  output logic [127:0] m_axis_tdata_o,
  // row_index in bits 1:0, degenerate in bit 2.
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam int unsigned DW     = lavm_pkg::DATA_W;
  localparam int unsigned SW     = lavm_pkg::SHR_W;
  localparam int unsigned W_W    = FRAC_BITS + 2;       // unit vector component
  localparam int unsigned PW     = DW + W_W;            // up times w
  localparam int unsigned PS_W   = PW + 2;              // dot product sum
  localparam int unsigned D_W    = PS_W - FRAC_BITS;    // projection length d
  localparam int unsigned DWP_W  = D_W + W_W;           // d times w
  localparam int unsigned SH_W   = DWP_W - FRAC_BITS;
  localparam int unsigned VR_W   = DW + 3;              // orthogonalized up
  localparam int unsigned CP_W   = 2 * W_W;             // cross product terms
  localparam int unsigned CD_W   = CP_W + 1;
  localparam int unsigned BP_W   = 2 * DW;              // basis times eye
  localparam int unsigned BS_W   = BP_W + 2;
  localparam int unsigned T_W    = BS_W - FRAC_BITS;
  localparam int unsigned N1_SW  = 6 * DW;
  localparam int unsigned N2_SW  = 3 * W_W + 3 * DW + 1;

  logic adv;

  // Input register.
  logic                in_v_q;
  logic [2:0][DW-1:0]  look_q;
  logic [2:0][DW-1:0]  up_q;
  logic [2:0][DW-1:0]  eye_q;

  // First normalizer: w is the negated unit look vector.
  logic                n1_v;
  logic [2:0][W_W-1:0] n1_vec;
  logic                n1_zero;
  logic [N1_SW-1:0]    n1_side;
  logic [2:0][DW-1:0]  n1_up;
  logic [2:0][DW-1:0]  n1_eye;
  logic [2:0][W_W-1:0] n1_w;

  // Orthogonalization stages.
  logic                   t1_v_q, t2_v_q, t3_v_q, t4_v_q, t5_v_q, t6_v_q;
  logic signed [PW-1:0]   t1_pw_q [3];
  logic signed [PS_W-1:0] t2_ps_q;
  logic signed [D_W-1:0]  t3_d_q;
  logic signed [DWP_W-1:0] t4_dw_q [3];
  logic signed [SH_W-1:0] t5_sh_q [3];
  logic [2:0][VR_W-1:0]   t6_vr_q;
  logic [2:0][W_W-1:0]    t1_w_q, t2_w_q, t3_w_q, t4_w_q, t5_w_q, t6_w_q;
  logic [2:0][DW-1:0]     t1_up_q, t2_up_q, t3_up_q, t4_up_q, t5_up_q;
  logic [2:0][DW-1:0]     t1_eye_q, t2_eye_q, t3_eye_q, t4_eye_q, t5_eye_q, t6_eye_q;
  logic                   t1_ok_q, t2_ok_q, t3_ok_q, t4_ok_q, t5_ok_q, t6_ok_q;

  // Second normalizer: v is the unit orthogonalized up vector.
  logic                n2_v;
  logic [2:0][W_W-1:0] n2_vec;
  logic                n2_zero;
  logic [N2_SW-1:0]    n2_side;
  logic [2:0][W_W-1:0] n2_w;
  logic [2:0][DW-1:0]  n2_eye;
  logic                n2_ok1;

  // Cross product stages: u = v x w.
  logic                   c1_v_q, c2_v_q, c3_v_q;
  logic signed [CP_W-1:0] c1_p_q [6];
  logic signed [CD_W-1:0] c2_x_q [3];
  logic signed [DW-1:0]   c3_u_q [3];
  logic [2:0][W_W-1:0]    c1_vv_q, c2_vv_q, c3_vv_q;
  logic [2:0][W_W-1:0]    c1_w_q, c2_w_q, c3_w_q;
  logic [2:0][DW-1:0]     c1_eye_q, c2_eye_q, c3_eye_q;
  logic                   c1_ok_q, c2_ok_q, c3_ok_q;

  // Translation stages, one lane per row.
  logic signed [DW-1:0]   bas [3][3];
  logic                   d1_v_q, d2_v_q, d3_v_q;
  logic signed [DW-1:0]   d1_b_q [3][3];
  logic signed [DW-1:0]   d2_b_q [3][3];
  logic signed [DW-1:0]   d3_b_q [3][3];
  logic signed [BP_W-1:0] d1_p_q [3][3];
  logic signed [BS_W-1:0] d2_s_q [3];
  logic signed [T_W-1:0]  d3_t_q [3];
  logic                   d1_deg_q, d2_deg_q, d3_deg_q;

  // Output holding stage; rows leave one per cycle while m_axis is ready.
  logic signed [SW-1:0]   neg_t [3];
  logic signed [DW-1:0]   sat_t [3];
  logic                   h_v_q;
  lavm_pkg::row_e         h_row_q;
  logic signed [DW-1:0]   h_b_q [3][3];
  logic signed [DW-1:0]   h_t_q [3];
  logic                   h_deg_q;
  logic [1:0]             sel;

  // The whole pipeline moves whenever the holding stage is empty or is
  // handing over its last row in this cycle.
  assign adv             = !h_v_q || (m_axis_tready_i && (h_row_q == lavm_pkg::ROW_W));
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
      t5_v_q <= 1'b0;
      t6_v_q <= 1'b0;
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      c3_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
      d3_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= s_axis_tvalid_i;
      t1_v_q <= n1_v;
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= t3_v_q;
      t5_v_q <= t4_v_q;
      t6_v_q <= t5_v_q;
      c1_v_q <= n2_v;
      c2_v_q <= c1_v_q;
      c3_v_q <= c2_v_q;
      d1_v_q <= c3_v_q;
      d2_v_q <= d1_v_q;
      d3_v_q <= d2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        look_q[k] <= s_axis_tdata_i[k*DW +: DW];
        up_q[k]   <= s_axis_tdata_i[(3+k)*DW +: DW];
        eye_q[k]  <= s_axis_tdata_i[(6+k)*DW +: DW];
      end
    end
  end

  lavm_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (DW),
    .SIDE_W    (N1_SW)
  ) u_norm_look (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_v_q),
    .vec_i   (look_q),
    .side_i  ({up_q, eye_q}),
    .valid_o (n1_v),
    .vec_o   (n1_vec),
    .zero_o  (n1_zero),
    .side_o  (n1_side)
  );

  assign {n1_up, n1_eye} = n1_side;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n1_w[k] = W_W'(-$signed(n1_vec[k]));
    end
  end

  // d = (up . w) >> FRAC_BITS, then v_raw = up - ((d * w) >> FRAC_BITS),
  // every shift truncating toward zero.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        t1_pw_q[k] <= PW'($signed(n1_up[k])) * PW'($signed(n1_w[k]));
        t4_dw_q[k] <= DWP_W'(t3_d_q) * DWP_W'($signed(t3_w_q[k]));
        t5_sh_q[k] <= SH_W'(lavm_pkg::shr_tz(SW'(t4_dw_q[k]), FRAC_BITS));
        t6_vr_q[k] <= VR_W'($signed(t5_up_q[k])) - VR_W'(t5_sh_q[k]);
      end
      t2_ps_q <= PS_W'(t1_pw_q[0]) + PS_W'(t1_pw_q[1]) + PS_W'(t1_pw_q[2]);
      t3_d_q  <= D_W'(lavm_pkg::shr_tz(SW'(t2_ps_q), FRAC_BITS));

      t1_w_q <= n1_w;    t2_w_q <= t1_w_q;   t3_w_q <= t2_w_q;
      t4_w_q <= t3_w_q;  t5_w_q <= t4_w_q;   t6_w_q <= t5_w_q;
      t1_up_q <= n1_up;  t2_up_q <= t1_up_q; t3_up_q <= t2_up_q;
      t4_up_q <= t3_up_q; t5_up_q <= t4_up_q;
      t1_eye_q <= n1_eye;   t2_eye_q <= t1_eye_q; t3_eye_q <= t2_eye_q;
      t4_eye_q <= t3_eye_q; t5_eye_q <= t4_eye_q; t6_eye_q <= t5_eye_q;
      t1_ok_q <= !n1_zero; t2_ok_q <= t1_ok_q; t3_ok_q <= t2_ok_q;
      t4_ok_q <= t3_ok_q;  t5_ok_q <= t4_ok_q; t6_ok_q <= t5_ok_q;
    end
  end

  lavm_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (VR_W),
    .SIDE_W    (N2_SW)
  ) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (t6_v_q),
    .vec_i   (t6_vr_q),
    .side_i  ({t6_w_q, t6_eye_q, t6_ok_q}),
    .valid_o (n2_v),
    .vec_o   (n2_vec),
    .zero_o  (n2_zero),
    .side_o  (n2_side)
  );

  assign {n2_w, n2_eye, n2_ok1} = n2_side;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_p_q[0] <= CP_W'($signed(n2_vec[1])) * CP_W'($signed(n2_w[2]));
      c1_p_q[1] <= CP_W'($signed(n2_vec[2])) * CP_W'($signed(n2_w[1]));
      c1_p_q[2] <= CP_W'($signed(n2_vec[2])) * CP_W'($signed(n2_w[0]));
      c1_p_q[3] <= CP_W'($signed(n2_vec[0])) * CP_W'($signed(n2_w[2]));
      c1_p_q[4] <= CP_W'($signed(n2_vec[0])) * CP_W'($signed(n2_w[1]));
      c1_p_q[5] <= CP_W'($signed(n2_vec[1])) * CP_W'($signed(n2_w[0]));
      for (int k = 0; k < 3; k++) begin
        c2_x_q[k] <= CD_W'(c1_p_q[2*k]) - CD_W'(c1_p_q[2*k+1]);
        c3_u_q[k] <= DW'(lavm_pkg::shr_tz(SW'(c2_x_q[k]), FRAC_BITS));
      end
      c1_vv_q  <= n2_vec;   c2_vv_q  <= c1_vv_q;  c3_vv_q  <= c2_vv_q;
      c1_w_q   <= n2_w;     c2_w_q   <= c1_w_q;   c3_w_q   <= c2_w_q;
      c1_eye_q <= n2_eye;   c2_eye_q <= c1_eye_q; c3_eye_q <= c2_eye_q;
      c1_ok_q  <= n2_ok1 && !n2_zero;
      c2_ok_q  <= c1_ok_q;
      c3_ok_q  <= c2_ok_q;
    end
  end

  // A degenerate camera clears the basis, which also clears the translation.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bas[0][k] = c3_ok_q ? c3_u_q[k] : '0;
      bas[1][k] = c3_ok_q ? DW'($signed(c3_vv_q[k])) : '0;
      bas[2][k] = c3_ok_q ? DW'($signed(c3_w_q[k])) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          d1_b_q[r][k] <= bas[r][k];
          d1_p_q[r][k] <= BP_W'(bas[r][k]) * BP_W'($signed(c3_eye_q[k]));
          d2_b_q[r][k] <= d1_b_q[r][k];
          d3_b_q[r][k] <= d2_b_q[r][k];
        end
        d2_s_q[r] <= BS_W'(d1_p_q[r][0]) + BS_W'(d1_p_q[r][1]) + BS_W'(d1_p_q[r][2]);
        d3_t_q[r] <= T_W'(lavm_pkg::shr_tz(SW'(d2_s_q[r]), FRAC_BITS));
      end
      d1_deg_q <= !c3_ok_q;
      d2_deg_q <= d1_deg_q;
      d3_deg_q <= d2_deg_q;
    end
  end

  // Negate and saturate the translation into the signed 32-bit range.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      neg_t[r] = -SW'(d3_t_q[r]);
      if (neg_t[r] > SW'(signed'(64'sd2147483647))) begin
        sat_t[r] = {1'b0, {(DW-1){1'b1}}};
      end else if (neg_t[r] < SW'(signed'(-64'sd2147483648))) begin
        sat_t[r] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        sat_t[r] = DW'(neg_t[r]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q   <= 1'b0;
      h_row_q <= lavm_pkg::ROW_U;
    end else if (adv) begin
      h_v_q   <= d3_v_q;
      h_row_q <= lavm_pkg::ROW_U;
    end else if (m_axis_tready_i) begin
      unique case (h_row_q)
        lavm_pkg::ROW_U: h_row_q <= lavm_pkg::ROW_V;
        lavm_pkg::ROW_V: h_row_q <= lavm_pkg::ROW_W;
        default:         h_row_q <= lavm_pkg::ROW_U;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_b_q   <= d3_b_q;
      h_t_q   <= sat_t;
      h_deg_q <= d3_deg_q;
    end
  end

  always_comb begin
    case (h_row_q)
      lavm_pkg::ROW_U: sel = 2'd0;
      lavm_pkg::ROW_V: sel = 2'd1;
      default:         sel = 2'd2;
    endcase
  end

  assign m_axis_tvalid_o = h_v_q;
  assign m_axis_tdata_o  = {h_t_q[sel], h_b_q[sel][2], h_b_q[sel][1], h_b_q[sel][0]};
  assign m_axis_tuser_o  = {h_deg_q, h_row_q};
  assign m_axis_tlast_o  = (h_row_q == lavm_pkg::ROW_W);

`ifndef SYNTHESIS
  // After the last row of a request the counter starts over.
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> (h_row_q == lavm_pkg::ROW_U))
    else $error("row counter did not wrap after the last row");

  // A stalled row keeps its place and stays on offer.
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(h_row_q)))
    else $error("stalled row moved on");

  // Degenerate rows carry an all-zero matrix row.
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2]) |-> (m_axis_tdata_o == '0))
    else $error("degenerate row with nonzero elements");

  // An empty holding stage always sits at the first row.
  a_idle_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !h_v_q |-> (h_row_q == lavm_pkg::ROW_U))
    else $error("row counter advanced without a request");
`endif

endmodule
